### sv/ph_mesh_segment_refiner_macros.svh
// Assertion macros for the mesh segment refiner checker.
`ifndef PH_MESH_SEGMENT_REFINER_MACROS_SVH
`define PH_MESH_SEGMENT_REFINER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PHMSR_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PHMSR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/phmsr_pkg.sv
// Shared constants, types and codes of the mesh segment refiner.
`timescale 1ns / 1ps
package phmsr_pkg;

  localparam int unsigned MAX_SPLITS_DEF = 16;
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned NODE_W         = 8;
  localparam int unsigned DIV_W          = 33;
  localparam int unsigned DEN_W          = 8;
  localparam int unsigned K_W            = 6;
  localparam int unsigned CFG_IDX_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_TOL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NMAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NMIN = 2'd2;

  localparam logic [DATA_W-1:0] TOL_RST  = 32'd1678;
  localparam logic [NODE_W-1:0] NMAX_RST = 8'd12;
  localparam logic [NODE_W-1:0] NMIN_RST = 8'd4;
  localparam logic [NODE_W-1:0] NODES_LO = 8'd2;
  localparam logic [K_W-1:0]    POW_K_MAX = 6'd32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POW,
    ST_DIV_BQ,
    ST_DIV_DIFF,
    ST_EMIT,
    ST_SPLIT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  num;
    logic [DEN_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_W-1:0]  quo;
    logic [DEN_W-1:0]  rem;
  } div_rsp_t;

  typedef struct packed {
    logic               go;
    logic [DATA_W-1:0]  emax;
    logic [NODE_W-1:0]  nodes;
    logic [DATA_W-1:0]  seg_a;
    logic [DATA_W-1:0]  seg_b;
  } seg_job_t;

  typedef struct packed {
    logic               valid;
    logic [DATA_W-1:0]  sub_start;
    logic [DATA_W-1:0]  sub_end;
    logic [NODE_W-1:0]  sub_nodes;
    logic               refined;
    logic               split_last;
  } sub_word_t;

endpackage

### sv/phmsr_if.sv
// Valid/ready channel interfaces for sample input and subinterval output words.
`timescale 1ns / 1ps
interface phmsr_in_if;
  import phmsr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [DATA_W-1:0]         err_sample;
  logic                      seg_last;
  logic [NODE_W-1:0]         nodes_now;
  logic signed [DATA_W-1:0]  mesh_start;
  logic signed [DATA_W-1:0]  mesh_end;

  modport source (output valid, err_sample, seg_last, nodes_now, mesh_start, mesh_end,
                  input ready);
  modport sink   (input valid, err_sample, seg_last, nodes_now, mesh_start, mesh_end,
                  output ready);
endinterface

interface phmsr_out_if;
  import phmsr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [DATA_W-1:0]  sub_start;
  logic signed [DATA_W-1:0]  sub_end;
  logic [NODE_W-1:0]         sub_nodes;
  logic                      refined;
  logic                      split_last;

  modport source (output valid, sub_start, sub_end, sub_nodes, refined, split_last,
                  input ready);
  modport sink   (input valid, sub_start, sub_end, sub_nodes, refined, split_last,
                  output ready);
endinterface

### sv/phmsr_div.sv
// Shared radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module phmsr_div (
  input  logic                clk,
  input  logic                rst_n,
  input  phmsr_pkg::div_req_t req,
  output phmsr_pkg::div_rsp_t rsp
);
  import phmsr_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;
  logic             qbit;

  always_comb begin
    trial    = {rem_r, quo_r[DIV_W-1]};
    qbit     = 1'b0;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt  = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
      cnt_nxt  = CNT_W'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        qbit    = 1'b1;
        rem_nxt = DEN_W'(trial - {1'b0, den_r});
      end else begin
        rem_nxt = trial[DEN_W-1:0];
      end
      quo_nxt = {quo_r[DIV_W-2:0], qbit};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

### sv/phmsr_ctrl.sv
// Segment-end sequencer: power search, split count and split point stepping.
`timescale 1ns / 1ps
module phmsr_ctrl #(
  parameter int unsigned MAX_SPLITS = phmsr_pkg::MAX_SPLITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  phmsr_pkg::seg_job_t               job,
  input  logic [phmsr_pkg::DATA_W-1:0]      tol,
  input  logic [phmsr_pkg::NODE_W-1:0]      nmax,
  input  logic [phmsr_pkg::NODE_W-1:0]      nmin,
  output logic                              busy,
  output phmsr_pkg::sub_word_t              word,
  input  logic                              word_take,
  output phmsr_pkg::div_req_t               dreq,
  input  phmsr_pkg::div_rsp_t               drsp
);
  import phmsr_pkg::*;

  localparam int unsigned BQ_W = $clog2(MAX_SPLITS + 1);

  state_t               state_r, state_nxt;
  logic [DATA_W-1:0]    emax_r, emax_nxt;
  logic [NODE_W-1:0]    nodes_r, nodes_nxt;
  logic [DATA_W-1:0]    a_r, a_nxt;
  logic [DATA_W-1:0]    b_r, b_nxt;
  logic [DATA_W-1:0]    p_r, p_nxt;
  logic [K_W-1:0]       k_r, k_nxt;
  logic [NODE_W-1:0]    en_nodes_r, en_nodes_nxt;
  logic                 en_ref_r, en_ref_nxt;
  logic [BQ_W-1:0]      bq_r, bq_nxt;
  logic [BQ_W-1:0]      idx_r, idx_nxt;
  logic [BQ_W-1:0]      rr_r, rr_nxt;
  logic [BQ_W-1:0]      rstep_r, rstep_nxt;
  logic [DIV_W-1:0]     qlo_r, qlo_nxt;
  logic [DIV_W-1:0]     qhi_r, qhi_nxt;
  logic [DIV_W-1:0]     qstep_r, qstep_nxt;

  logic [NODE_W-1:0]          nodes_in;
  logic [NODE_W-1:0]          nm;
  logic [DATA_W+NODE_W-1:0]   prod;
  logic                       pow_go;
  logic [NODE_W:0]            newn;
  logic                       need_split;
  logic [BQ_W-1:0]            bq_sel;
  logic [DIV_W-1:0]           diff;
  logic [DIV_W-1:0]           absd;
  logic [BQ_W:0]              rsum;
  logic                       sub_last;
  logic                       take;

  assign nodes_in   = (job.nodes < NODES_LO) ? NODES_LO : job.nodes;
  assign nm         = (nmin < NODES_LO) ? NODES_LO : nmin;
  assign prod       = p_r * nodes_r;
  assign pow_go     = (k_r < POW_K_MAX) && (prod <= (DATA_W+NODE_W)'(emax_r));
  assign newn       = {1'b0, nodes_r} + (NODE_W+1)'(k_r);
  assign need_split = newn > {1'b0, nmax};
  assign diff       = {b_r[DATA_W-1], b_r} - {a_r[DATA_W-1], a_r};
  assign absd       = diff[DIV_W-1] ? (~diff + 1'b1) : diff;
  assign rsum       = {1'b0, rr_r} + {1'b0, rstep_r};
  assign sub_last   = ({1'b0, idx_r} + 1'b1) == {1'b0, bq_r};
  assign take       = word.valid && word_take;

  always_comb begin
    if (drsp.quo < DIV_W'(2)) begin
      bq_sel = BQ_W'(2);
    end else if (drsp.quo > DIV_W'(MAX_SPLITS)) begin
      bq_sel = BQ_W'(MAX_SPLITS);
    end else begin
      bq_sel = drsp.quo[BQ_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (job.go) begin
          state_nxt = (job.emax <= tol) ? ST_EMIT : ST_POW;
        end
      end
      ST_POW: begin
        if (!pow_go) begin
          state_nxt = need_split ? ST_DIV_BQ : ST_EMIT;
        end
      end
      ST_DIV_BQ: begin
        if (drsp.done) begin
          state_nxt = ST_DIV_DIFF;
        end
      end
      ST_DIV_DIFF: begin
        if (drsp.done) begin
          state_nxt = ST_SPLIT;
        end
      end
      ST_EMIT: begin
        if (take) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SPLIT: begin
        if (take && sub_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    emax_nxt     = emax_r;
    nodes_nxt    = nodes_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    p_nxt        = p_r;
    k_nxt        = k_r;
    en_nodes_nxt = en_nodes_r;
    en_ref_nxt   = en_ref_r;
    bq_nxt       = bq_r;
    idx_nxt      = idx_r;
    rr_nxt       = rr_r;
    rstep_nxt    = rstep_r;
    qlo_nxt      = qlo_r;
    qhi_nxt      = qhi_r;
    qstep_nxt    = qstep_r;
    unique case (state_r)
      ST_IDLE: begin
        if (job.go) begin
          emax_nxt     = job.emax;
          nodes_nxt    = nodes_in;
          a_nxt        = job.seg_a;
          b_nxt        = job.seg_b;
          p_nxt        = tol;
          k_nxt        = '0;
          en_nodes_nxt = nodes_in;
          en_ref_nxt   = 1'b0;
        end
      end
      ST_POW: begin
        if (pow_go) begin
          p_nxt = prod[DATA_W-1:0];
          k_nxt = k_r + 1'b1;
        end else begin
          en_nodes_nxt = newn[NODE_W] ? {NODE_W{1'b1}} : newn[NODE_W-1:0];
          en_ref_nxt   = 1'b1;
        end
      end
      ST_DIV_BQ: begin
        if (drsp.done) begin
          bq_nxt = bq_sel;
        end
      end
      ST_DIV_DIFF: begin
        if (drsp.done) begin
          if (!diff[DIV_W-1]) begin
            qstep_nxt = drsp.quo;
            rstep_nxt = BQ_W'(drsp.rem);
          end else if (drsp.rem == '0) begin
            qstep_nxt = ~drsp.quo + 1'b1;
            rstep_nxt = '0;
          end else begin
            // floor toward minus infinity
            qstep_nxt = ~drsp.quo;
            rstep_nxt = BQ_W'(DEN_W'(bq_r) - drsp.rem);
          end
          qlo_nxt = '0;
          idx_nxt = '0;
          if (!diff[DIV_W-1]) begin
            qhi_nxt = drsp.quo;
            rr_nxt  = BQ_W'(drsp.rem);
          end else if (drsp.rem == '0) begin
            qhi_nxt = ~drsp.quo + 1'b1;
            rr_nxt  = '0;
          end else begin
            qhi_nxt = ~drsp.quo;
            rr_nxt  = BQ_W'(DEN_W'(bq_r) - drsp.rem);
          end
        end
      end
      ST_EMIT: begin
      end
      ST_SPLIT: begin
        if (take) begin
          qlo_nxt = qhi_r;
          idx_nxt = idx_r + 1'b1;
          if (rsum >= {1'b0, bq_r}) begin
            rr_nxt  = BQ_W'(rsum - {1'b0, bq_r});
            qhi_nxt = qhi_r + qstep_r + 1'b1;
          end else begin
            rr_nxt  = rsum[BQ_W-1:0];
            qhi_nxt = qhi_r + qstep_r;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // outputs
  always_comb begin
    busy = (state_r != ST_IDLE);
    word = '0;
    dreq = '0;
    unique case (state_r)
      ST_IDLE: begin
      end
      ST_POW: begin
        dreq.start = !pow_go && need_split;
        dreq.num   = DIV_W'({1'b0, newn} + (NODE_W+2)'(nm) - 1'b1);
        dreq.den   = DEN_W'(nm);
      end
      ST_DIV_BQ: begin
        dreq.start = drsp.done;
        dreq.num   = absd;
        dreq.den   = DEN_W'(bq_sel);
      end
      ST_DIV_DIFF: begin
      end
      ST_EMIT: begin
        word.valid      = 1'b1;
        word.sub_start  = a_r;
        word.sub_end    = b_r;
        word.sub_nodes  = en_nodes_r;
        word.refined    = en_ref_r;
        word.split_last = 1'b1;
      end
      ST_SPLIT: begin
        word.valid      = 1'b1;
        word.sub_start  = a_r + qlo_r[DATA_W-1:0];
        word.sub_end    = a_r + qhi_r[DATA_W-1:0];
        word.sub_nodes  = nm;
        word.refined    = 1'b1;
        word.split_last = sub_last;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    emax_r     <= emax_nxt;
    nodes_r    <= nodes_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    p_r        <= p_nxt;
    k_r        <= k_nxt;
    en_nodes_r <= en_nodes_nxt;
    en_ref_r   <= en_ref_nxt;
    bq_r       <= bq_nxt;
    idx_r      <= idx_nxt;
    rr_r       <= rr_nxt;
    rstep_r    <= rstep_nxt;
    qlo_r      <= qlo_nxt;
    qhi_r      <= qhi_nxt;
    qstep_r    <= qstep_nxt;
  end

endmodule

### sv/ph_mesh_segment_refiner.sv
// Mesh segment refiner top level: config registers, running max, output register.
// Non-final sample word: accepted while idle and folded into the running max; ready stays high.
// Final word, segment within tolerance: emit state, then the word is loaded into the output register.
// Raised order: a power search (one 32x8 multiply per step), then the emit state.
// Split: power search, two passes of the shared divider, then one subinterval word per
//   cycle unless the output stalls; input ready stays low until the last is handed over.
// Reset (synchronous, rst_n low): tol 1678, nmax 12, nmin 4, running max 0, idle.
`timescale 1ns / 1ps
module ph_mesh_segment_refiner #(
  parameter int unsigned MAX_SPLITS = phmsr_pkg::MAX_SPLITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  phmsr_in_if.sink                             in_ch,
  phmsr_out_if.source                          out_ch,
  input  logic                                 cfg_we,
  input  logic [phmsr_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [phmsr_pkg::DATA_W-1:0]         cfg_wdata
);
  import phmsr_pkg::*;

  logic [DATA_W-1:0] tol_r;
  logic [NODE_W-1:0] nmax_r;
  logic [NODE_W-1:0] nmin_r;
  logic [DATA_W-1:0] rmax_r, rmax_nxt;
  logic              oval_r, oval_nxt;
  sub_word_t         oword_r;

  logic              busy;
  logic              in_acc;
  logic [DATA_W-1:0] emax;
  logic              word_take;
  seg_job_t          job;
  sub_word_t         word;
  div_req_t          dreq;
  div_rsp_t          drsp;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !busy;
  assign emax      = (rmax_r > in_ch.err_sample) ? rmax_r : in_ch.err_sample;
  assign word_take = !oval_r || out_ch.ready;

  assign job.go    = in_acc && in_ch.seg_last;
  assign job.emax  = emax;
  assign job.nodes = in_ch.nodes_now;
  assign job.seg_a = in_ch.mesh_start;
  assign job.seg_b = in_ch.mesh_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r  <= TOL_RST;
      nmax_r <= NMAX_RST;
      nmin_r <= NMIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_TOL:  tol_r  <= cfg_wdata;
        REG_NMAX: nmax_r <= cfg_wdata[NODE_W-1:0];
        REG_NMIN: nmin_r <= cfg_wdata[NODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    rmax_nxt = rmax_r;
    if (in_acc) begin
      rmax_nxt = in_ch.seg_last ? '0 : emax;
    end
  end

  always_comb begin
    oval_nxt = oval_r;
    if (word.valid && word_take) begin
      oval_nxt = 1'b1;
    end else if (out_ch.ready) begin
      oval_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rmax_r <= '0;
      oval_r <= 1'b0;
    end else begin
      rmax_r <= rmax_nxt;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (word.valid && word_take) begin
      oword_r <= word;
    end
  end

  assign out_ch.valid      = oval_r;
  assign out_ch.sub_start  = oword_r.sub_start;
  assign out_ch.sub_end    = oword_r.sub_end;
  assign out_ch.sub_nodes  = oword_r.sub_nodes;
  assign out_ch.refined    = oword_r.refined;
  assign out_ch.split_last = oword_r.split_last;

  phmsr_ctrl #(
    .MAX_SPLITS (MAX_SPLITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job),
    .tol       (tol_r),
    .nmax      (nmax_r),
    .nmin      (nmin_r),
    .busy      (busy),
    .word      (word),
    .word_take (word_take),
    .dreq      (dreq),
    .drsp      (drsp)
  );

  phmsr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

endmodule

### sv/phmsr_chk.sv
// Port-level checker for the mesh segment refiner, bound to the top level.
`timescale 1ns / 1ps
`include "ph_mesh_segment_refiner_macros.svh"
module phmsr_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_seg_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_sub_start,
  input logic [7:0]  out_sub_nodes,
  input logic        out_refined,
  input logic        out_split_last
);

  `PHMSR_ASSERT_NXT(a_last_busy, in_valid && in_ready && in_seg_last, !in_ready, "ready after final word")
  `PHMSR_ASSERT_NXT(a_mid_ready, in_valid && in_ready && !in_seg_last, in_ready, "ready lost on sample word")
  `PHMSR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_sub_start), "output word changed while stalled")
  `PHMSR_ASSERT(a_plain_last, out_valid && !out_refined, out_split_last, "unchanged segment not single word")
  `PHMSR_ASSERT(a_nodes_lo, out_valid, out_sub_nodes >= 8'd2, "node count below two")

endmodule

bind ph_mesh_segment_refiner phmsr_chk u_phmsr_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_seg_last    (in_ch.seg_last),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_sub_start  (out_ch.sub_start),
  .out_sub_nodes  (out_ch.sub_nodes),
  .out_refined    (out_ch.refined),
  .out_split_last (out_ch.split_last)
);
